// ----- src/scbr_pkg.sv -----
// ----------------------------------------------------------------------------
// scbr_pkg
// Shared types and constants for the SPI chip-select byte router.
// ----------------------------------------------------------------------------
package scbr_pkg;

    // Buffer depths
    localparam int PANEL_BYTES = 5;
    localparam int LED_BYTES   = 5;

    // Bytes that fit in the 40-bit panel and LED fields
    localparam int FIELD_BYTES     = 5;
    localparam int PANEL_IN_BYTES  = (PANEL_BYTES < FIELD_BYTES) ? PANEL_BYTES : FIELD_BYTES;
    localparam int LED_OUT_BYTES   = (LED_BYTES < FIELD_BYTES) ? LED_BYTES : FIELD_BYTES;

    // Counter widths: each must hold its depth itself
    localparam int POS_W      = $clog2(PANEL_BYTES + 1);
    localparam int LED_FILL_W = $clog2(LED_BYTES + 1);

    localparam logic [7:0]  MISO_IDLE    = 8'hFF;
    localparam logic [15:0] DAC_CH_MASK  = 16'h1000;
    localparam logic [15:0] DAC_VAL_MASK = 16'h0FFF;
    localparam int          DAC_VAL_LSB  = 5;
    localparam logic [2:0]  LED_LEN_MAX  = 3'd7;

    typedef enum logic [2:0] {
        OP_BYTE = 3'd0,
        OP_SW   = 3'd1,
        OP_LED  = 3'd2,
        OP_TRIG = 3'd3,
        OP_DAC  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_LED  = 2'd1,
        EV_TRIG = 2'd2,
        EV_DAC  = 2'd3
    } t_event;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  data_value;
        logic [39:0] panel_bits;
        logic [7:0]  porta_value;
        logic [7:0]  portd_value;
        logic [47:0] cycle_stamp;
    } t_item;

    typedef struct packed {
        logic        miso_valid;
        logic [7:0]  miso_byte;
        t_event      event_kind;
        logic [39:0] led_bytes;
        logic [2:0]  led_length;
        logic [15:0] trigger_word;
        logic        dac_channel;
        logic [6:0]  dac_velocity;
        logic [47:0] event_stamp;
        logic [31:0] scan_total;
        logic [7:0]  porta_snap;
        logic [7:0]  portd_snap;
    } t_result;

endpackage

// ----- src/spi_chip_select_byte_router.sv -----
// ----------------------------------------------------------------------------
// spi_chip_select_byte_router
// Peripheral side of one SPI bus with switch, LED, trigger and DAC selects.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: an SPI byte
//   or one edge on one chip select, plus the panel, port and stamp samples.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   request, in order: an optional MISO byte, an optional event (LED write,
//   trigger word or DAC write) and the current snapshot count and port holds.
//   Flow: an accepted request is held in the input register and moves into
//   the output register when the output register is free.
//   Throughput: one request per clock unless the output stalls. The input
//   register feeds a single pass of decode and buffer logic into the output
//   register; state registers update in the same cycle the result is registered.
//   Reset (i_rst_n low at a clock edge): no select active, buffers, fills,
//   port holds and the snapshot count cleared, both pipeline stages empty.
//   Receiver stall: the output register holds its result; one further
//   request waits in the input register, then o_in_ready drops until the
//   output is taken.
// ----------------------------------------------------------------------------
module spi_chip_select_byte_router import scbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data_value,
    input  logic [39:0] i_panel_bits,
    input  logic [7:0]  i_porta_value,
    input  logic [7:0]  i_portd_value,
    input  logic [47:0] i_cycle_stamp,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_miso_valid,
    output logic [7:0]  o_miso_byte,
    output logic [1:0]  o_event_kind,
    output logic [39:0] o_led_bytes,
    output logic [2:0]  o_led_length,
    output logic [15:0] o_trigger_word,
    output logic        o_dac_channel,
    output logic [6:0]  o_dac_velocity,
    output logic [47:0] o_event_stamp,
    output logic [31:0] o_scan_total,
    output logic [7:0]  o_porta_snap,
    output logic [7:0]  o_portd_snap
);

    // input stage
    logic    r_in_valid;
    t_item   r_in;
    // output stage
    logic    r_out_valid;
    t_result r_out;

    t_result core_result;
    logic    advance;   // request in the input stage moves to the output stage
    logic    take_in;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take_in    = i_in_valid && o_in_ready;

    scbr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in.opcode      <= i_opcode;
            r_in.data_value  <= i_data_value;
            r_in.panel_bits  <= i_panel_bits;
            r_in.porta_value <= i_porta_value;
            r_in.portd_value <= i_portd_value;
            r_in.cycle_stamp <= i_cycle_stamp;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_miso_valid   = r_out.miso_valid;
    assign o_miso_byte    = r_out.miso_byte;
    assign o_event_kind   = r_out.event_kind;
    assign o_led_bytes    = r_out.led_bytes;
    assign o_led_length   = r_out.led_length;
    assign o_trigger_word = r_out.trigger_word;
    assign o_dac_channel  = r_out.dac_channel;
    assign o_dac_velocity = r_out.dac_velocity;
    assign o_event_stamp  = r_out.event_stamp;
    assign o_scan_total   = r_out.scan_total;
    assign o_porta_snap   = r_out.porta_snap;
    assign o_portd_snap   = r_out.portd_snap;

endmodule

// ----- src/scbr_core.sv -----
// ----------------------------------------------------------------------------
// scbr_core
// Select tracking, byte buffers and snapshot state; forms one result per
// request from the current state in a single pass.
// ----------------------------------------------------------------------------
module scbr_core import scbr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    typedef enum logic [2:0] {
        SEL_NONE = 3'd0,
        SEL_SW   = 3'd1,
        SEL_LED  = 3'd2,
        SEL_TRIG = 3'd3,
        SEL_DAC  = 3'd4
    } t_sel;

    t_sel                  r_sel,       n_sel;
    logic [7:0]            r_panel     [PANEL_BYTES];
    logic [7:0]            n_panel     [PANEL_BYTES];
    logic [POS_W-1:0]      r_shift_pos, n_shift_pos;
    logic [7:0]            r_led       [LED_BYTES];
    logic [7:0]            n_led       [LED_BYTES];
    logic [LED_FILL_W-1:0] r_led_fill,  n_led_fill;
    logic [7:0]            r_trig      [2];
    logic [7:0]            n_trig      [2];
    logic [1:0]            r_trig_fill, n_trig_fill;
    logic [7:0]            r_dac       [2];
    logic [7:0]            n_dac       [2];
    logic [1:0]            r_dac_fill,  n_dac_fill;
    logic [7:0]            r_porta,     n_porta;
    logic [7:0]            r_portd,     n_portd;
    logic [31:0]           r_scan_cnt,  n_scan_cnt;

    logic       level;
    logic [15:0] dac_word;
    t_result    res;

    assign level    = i_item.data_value[0];
    assign dac_word = {r_dac[0], r_dac[1]};

    always_comb begin
        n_sel       = r_sel;
        n_panel     = r_panel;
        n_shift_pos = r_shift_pos;
        n_led       = r_led;
        n_led_fill  = r_led_fill;
        n_trig      = r_trig;
        n_trig_fill = r_trig_fill;
        n_dac       = r_dac;
        n_dac_fill  = r_dac_fill;
        n_porta     = r_porta;
        n_portd     = r_portd;
        n_scan_cnt  = r_scan_cnt;
        res         = '0;
        res.event_kind = EV_NONE;

        unique case (t_opcode'(i_item.opcode))
            OP_BYTE: begin
                unique case (r_sel)
                    SEL_SW: begin
                        res.miso_valid = 1'b1;
                        if (r_shift_pos < POS_W'(PANEL_BYTES)) begin
                            for (int i = 0; i < PANEL_BYTES; i++) begin
                                if (r_shift_pos == POS_W'(i)) begin
                                    res.miso_byte = r_panel[i];
                                end
                            end
                            n_shift_pos = r_shift_pos + POS_W'(1);
                        end else begin
                            res.miso_byte = MISO_IDLE;
                        end
                    end
                    SEL_LED: begin
                        if (r_led_fill < LED_FILL_W'(LED_BYTES)) begin
                            for (int i = 0; i < LED_BYTES; i++) begin
                                if (r_led_fill == LED_FILL_W'(i)) begin
                                    n_led[i] = i_item.data_value;
                                end
                            end
                            n_led_fill = r_led_fill + LED_FILL_W'(1);
                        end
                    end
                    SEL_TRIG: begin
                        if (r_trig_fill < 2'd2) begin
                            n_trig[r_trig_fill[0]] = i_item.data_value;
                            n_trig_fill = r_trig_fill + 2'd1;
                        end
                    end
                    SEL_DAC: begin
                        if (r_dac_fill < 2'd2) begin
                            n_dac[r_dac_fill[0]] = i_item.data_value;
                            n_dac_fill = r_dac_fill + 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_SW: begin
                if (level) begin
                    for (int i = 0; i < PANEL_BYTES; i++) begin
                        n_panel[i] = 8'h00;
                    end
                    for (int i = 0; i < PANEL_IN_BYTES; i++) begin
                        n_panel[i] = i_item.panel_bits[8*i +: 8];
                    end
                    n_shift_pos = '0;
                    n_sel       = SEL_SW;
                    n_scan_cnt  = r_scan_cnt + 32'd1;
                end else if (r_sel == SEL_SW) begin
                    n_sel = SEL_NONE;
                end
            end
            OP_LED: begin
                if (!level) begin
                    n_led_fill = '0;
                    n_sel      = SEL_LED;
                end else begin
                    if (r_sel == SEL_LED && r_led_fill != '0) begin
                        res.event_kind = EV_LED;
                        for (int i = 0; i < LED_OUT_BYTES; i++) begin
                            if (LED_FILL_W'(i) < r_led_fill) begin
                                res.led_bytes[8*i +: 8] = r_led[i];
                            end
                        end
                        res.led_length  = (32'(r_led_fill) > 32'(LED_LEN_MAX)) ?
                                          LED_LEN_MAX : 3'(r_led_fill);
                        res.event_stamp = i_item.cycle_stamp;
                    end
                    n_sel = SEL_NONE;
                end
            end
            OP_TRIG: begin
                if (!level) begin
                    n_trig_fill = '0;
                    n_sel       = SEL_TRIG;
                end else begin
                    if (r_sel == SEL_TRIG && r_trig_fill == 2'd2) begin
                        res.event_kind   = EV_TRIG;
                        res.trigger_word = {r_trig[0], r_trig[1]};
                        res.event_stamp  = i_item.cycle_stamp;
                    end
                    n_sel = SEL_NONE;
                end
            end
            OP_DAC: begin
                if (!level) begin
                    n_porta    = i_item.porta_value;
                    n_portd    = i_item.portd_value;
                    n_dac_fill = '0;
                    n_sel      = SEL_DAC;
                end else begin
                    if (r_sel == SEL_DAC && r_dac_fill == 2'd2) begin
                        res.event_kind   = EV_DAC;
                        res.dac_channel  = ((dac_word & DAC_CH_MASK) == '0);
                        res.dac_velocity = 7'((dac_word & DAC_VAL_MASK) >> DAC_VAL_LSB);
                        res.event_stamp  = i_item.cycle_stamp;
                    end
                    n_sel = SEL_NONE;
                end
            end
            default: begin
            end
        endcase

        // state views show the value after this request
        res.scan_total = n_scan_cnt;
        res.porta_snap = n_porta;
        res.portd_snap = n_portd;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= SEL_NONE;
            r_shift_pos <= '0;
            r_led_fill  <= '0;
            r_trig_fill <= '0;
            r_dac_fill  <= '0;
            r_porta     <= '0;
            r_portd     <= '0;
            r_scan_cnt  <= '0;
            for (int i = 0; i < PANEL_BYTES; i++) r_panel[i] <= '0;
            for (int i = 0; i < LED_BYTES; i++)   r_led[i]   <= '0;
            for (int i = 0; i < 2; i++) begin
                r_trig[i] <= '0;
                r_dac[i]  <= '0;
            end
        end else if (i_fire) begin
            r_sel       <= n_sel;
            r_panel     <= n_panel;
            r_shift_pos <= n_shift_pos;
            r_led       <= n_led;
            r_led_fill  <= n_led_fill;
            r_trig      <= n_trig;
            r_trig_fill <= n_trig_fill;
            r_dac       <= n_dac;
            r_dac_fill  <= n_dac_fill;
            r_porta     <= n_porta;
            r_portd     <= n_portd;
            r_scan_cnt  <= n_scan_cnt;
        end
    end

endmodule
